// File: design/kpdc_pkg.sv
// Shared types and constants for the key press-duration classifier
`default_nettype none
package kpdc_pkg;

  localparam int LEVEL_W        = 18;
  localparam int KEYS_OUT       = 18;
  localparam int STATUS_W       = 3;
  localparam int OUT_W          = KEYS_OUT * STATUS_W;
  localparam int CFG_W          = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int THR_FIELD_W    = 16;
  localparam int KEYS_PER_REG   = 4;
  localparam int RESET_THRESHOLD = 50;

  typedef enum logic [STATUS_W-1:0] {
    ST_RELEASE    = 3'd0,
    ST_TO_PRESS   = 3'd1,
    ST_SHORT      = 3'd2,
    ST_LONG       = 3'd3,
    ST_TO_RELEASE = 3'd4
  } status_t;

  typedef struct packed {
    logic                   we;
    logic [THR_FIELD_W-1:0] data;
  } thr_wr_t;

endpackage
`default_nettype wire

// File: design/kpdc_lane.sv
// One key lane: hold counter, threshold register and status classification
`default_nettype none
module kpdc_lane #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire kpdc_pkg::thr_wr_t                  thr_wr,
  input  wire logic                               advance,
  input  wire logic                               level,
  output      kpdc_pkg::status_t                  status,
  output      kpdc_pkg::status_t                  status_next
);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX   = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE   = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] THR_RESET = COUNT_WIDTH'(kpdc_pkg::RESET_THRESHOLD);

  logic [COUNT_WIDTH-1:0] threshold;
  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH-1:0] count_inc;

  always_comb begin
    count_inc = (count == CNT_MAX) ? count : count + CNT_ONE;
    if (!level) begin
      status_next = (count != '0) ? kpdc_pkg::ST_TO_RELEASE : kpdc_pkg::ST_RELEASE;
      count_next  = '0;
    end else if (count_inc == CNT_ONE) begin
      status_next = kpdc_pkg::ST_TO_PRESS;
      count_next  = count_inc;
    end else if (count_inc >= threshold) begin
      status_next = kpdc_pkg::ST_LONG;
      count_next  = threshold;
    end else begin
      status_next = kpdc_pkg::ST_SHORT;
      count_next  = count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
      count     <= '0;
      status    <= kpdc_pkg::ST_RELEASE;
    end else begin
      if (thr_wr.we) begin
        threshold <= thr_wr.data[COUNT_WIDTH-1:0];
      end
      if (advance) begin
        count  <= count_next;
        status <= status_next;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/kpdc_merge.sv
// Result stage: two-entry output buffer holding packed new and previous statuses
`default_nettype none
module kpdc_merge (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire logic [kpdc_pkg::OUT_W-1:0] new_packed,
  input  wire logic [kpdc_pkg::OUT_W-1:0] old_packed,
  output      logic                       ready,
  output      logic                       result_valid,
  input  wire logic                       result_ready,
  output      logic [kpdc_pkg::OUT_W-1:0] key_statuses,
  output      logic [kpdc_pkg::OUT_W-1:0] previous_statuses
);

  logic                       main_valid;
  logic                       skid_valid;
  logic [kpdc_pkg::OUT_W-1:0] skid_new;
  logic [kpdc_pkg::OUT_W-1:0] skid_old;
  logic                       pop;

  assign pop          = main_valid && result_ready;
  assign ready        = !skid_valid;
  assign result_valid = main_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      key_statuses      <= skid_new;
      previous_statuses <= skid_old;
    end else if (push && (pop || !main_valid)) begin
      key_statuses      <= new_packed;
      previous_statuses <= old_packed;
    end
    if (push && main_valid && !pop) begin
      skid_new <= new_packed;
      skid_old <= old_packed;
    end
  end

endmodule
`default_nettype wire

// File: design/key_press_duration_classifier.sv
// Top level of the key press-duration classifier
`default_nettype none
// One item is one sampling tick of 18 key levels; each gives exactly one result
// with the new and the previous 3-bit status of every key. An item is taken every
// cycle while the output buffer has room, its result registered there; each key
// has its own lane holding a saturating hold counter and a threshold compare, all
// lanes working in the same cycle. The two-entry output buffer keeps taking input
// after a result stall until its second entry fills. Thresholds reset to 50 and
// are written four keys per register, only their low COUNT_WIDTH bits taking effect.
module key_press_duration_classifier #(
  parameter int NUM_KEYS    = 18,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [kpdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [kpdc_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                             item_valid,
  output      logic                             item_ready,
  input  wire logic [kpdc_pkg::LEVEL_W-1:0]     key_levels,
  output      logic                             result_valid,
  input  wire logic                             result_ready,
  output      logic [kpdc_pkg::OUT_W-1:0]       key_statuses,
  output      logic [kpdc_pkg::OUT_W-1:0]       previous_statuses
);

  localparam int LANES = (NUM_KEYS < kpdc_pkg::KEYS_OUT) ? NUM_KEYS : kpdc_pkg::KEYS_OUT;

  logic                       advance;
  logic [kpdc_pkg::OUT_W-1:0] new_packed;
  logic [kpdc_pkg::OUT_W-1:0] old_packed;

  assign advance = item_valid && item_ready;

  genvar k;
  generate
    for (k = 0; k < kpdc_pkg::KEYS_OUT; k++) begin : g_key
      if (k < LANES) begin : g_lane
        localparam int RegIdx = k / kpdc_pkg::KEYS_PER_REG;
        localparam int Slot   = k % kpdc_pkg::KEYS_PER_REG;
        kpdc_pkg::thr_wr_t thr_wr;
        kpdc_pkg::status_t status;
        kpdc_pkg::status_t status_next;

        assign thr_wr.we   = cfg_we && (cfg_index == kpdc_pkg::CFG_IDX_W'(RegIdx));
        assign thr_wr.data = cfg_data[kpdc_pkg::THR_FIELD_W*Slot +: kpdc_pkg::THR_FIELD_W];

        kpdc_lane #(
          .COUNT_WIDTH(COUNT_WIDTH)
        ) u_lane (
          .clk         (clk),
          .rst         (rst),
          .thr_wr      (thr_wr),
          .advance     (advance),
          .level       (key_levels[k]),
          .status      (status),
          .status_next (status_next)
        );

        assign new_packed[kpdc_pkg::STATUS_W*k +: kpdc_pkg::STATUS_W] = status_next;
        assign old_packed[kpdc_pkg::STATUS_W*k +: kpdc_pkg::STATUS_W] = status;
      end else begin : g_absent
        assign new_packed[kpdc_pkg::STATUS_W*k +: kpdc_pkg::STATUS_W] = kpdc_pkg::ST_RELEASE;
        assign old_packed[kpdc_pkg::STATUS_W*k +: kpdc_pkg::STATUS_W] = kpdc_pkg::ST_RELEASE;
      end
    end
  endgenerate

  kpdc_merge u_merge (
    .clk               (clk),
    .rst               (rst),
    .push              (advance),
    .new_packed        (new_packed),
    .old_packed        (old_packed),
    .ready             (item_ready),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .key_statuses      (key_statuses),
    .previous_statuses (previous_statuses)
  );

`ifndef SYNTHESIS
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid)
    else $error("input stalled with no result waiting");

  a_item_gives_result: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && !result_valid |=> result_valid)
    else $error("accepted item did not reach the output");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !result_valid && item_ready)
    else $error("output buffer not empty after reset");
`endif

endmodule
`default_nettype wire
